// File: rtl/imaenc_pkg.sv
// shared types, constants and tables for the ima adpcm frame encoder
`timescale 1ns / 1ps

package imaenc_pkg;

	localparam int unsigned FRAME_SAMPLES = 60;
	localparam int unsigned POS_W = (FRAME_SAMPLES > 2) ? $clog2(FRAME_SAMPLES) : 1;
	localparam int unsigned IDX_MAX = 88;
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic signed [17:0] PRED_MAX = 18'sd32767;
	localparam logic signed [17:0] PRED_MIN = -18'sd32768;

	typedef struct packed {
		logic signed [15:0] predictor;
		logic [6:0]         step_index;
	} enc_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_header;
		logic       frame_last;
	} out_entry_t;

	function automatic logic [14:0] step_val(input logic [6:0] idx);
		logic [14:0] v;
		unique case (idx)
			7'd0:  v = 15'd7;     7'd1:  v = 15'd8;     7'd2:  v = 15'd9;
			7'd3:  v = 15'd10;    7'd4:  v = 15'd11;    7'd5:  v = 15'd12;
			7'd6:  v = 15'd13;    7'd7:  v = 15'd14;    7'd8:  v = 15'd16;
			7'd9:  v = 15'd17;    7'd10: v = 15'd19;    7'd11: v = 15'd21;
			7'd12: v = 15'd23;    7'd13: v = 15'd25;    7'd14: v = 15'd28;
			7'd15: v = 15'd31;    7'd16: v = 15'd34;    7'd17: v = 15'd37;
			7'd18: v = 15'd41;    7'd19: v = 15'd45;    7'd20: v = 15'd50;
			7'd21: v = 15'd55;    7'd22: v = 15'd60;    7'd23: v = 15'd66;
			7'd24: v = 15'd73;    7'd25: v = 15'd80;    7'd26: v = 15'd88;
			7'd27: v = 15'd97;    7'd28: v = 15'd107;   7'd29: v = 15'd118;
			7'd30: v = 15'd130;   7'd31: v = 15'd143;   7'd32: v = 15'd157;
			7'd33: v = 15'd173;   7'd34: v = 15'd190;   7'd35: v = 15'd209;
			7'd36: v = 15'd230;   7'd37: v = 15'd253;   7'd38: v = 15'd279;
			7'd39: v = 15'd307;   7'd40: v = 15'd337;   7'd41: v = 15'd371;
			7'd42: v = 15'd408;   7'd43: v = 15'd449;   7'd44: v = 15'd494;
			7'd45: v = 15'd544;   7'd46: v = 15'd598;   7'd47: v = 15'd658;
			7'd48: v = 15'd724;   7'd49: v = 15'd796;   7'd50: v = 15'd876;
			7'd51: v = 15'd963;   7'd52: v = 15'd1060;  7'd53: v = 15'd1166;
			7'd54: v = 15'd1282;  7'd55: v = 15'd1411;  7'd56: v = 15'd1552;
			7'd57: v = 15'd1707;  7'd58: v = 15'd1878;  7'd59: v = 15'd2066;
			7'd60: v = 15'd2272;  7'd61: v = 15'd2499;  7'd62: v = 15'd2749;
			7'd63: v = 15'd3024;  7'd64: v = 15'd3327;  7'd65: v = 15'd3660;
			7'd66: v = 15'd4026;  7'd67: v = 15'd4428;  7'd68: v = 15'd4871;
			7'd69: v = 15'd5358;  7'd70: v = 15'd5894;  7'd71: v = 15'd6484;
			7'd72: v = 15'd7132;  7'd73: v = 15'd7845;  7'd74: v = 15'd8630;
			7'd75: v = 15'd9493;  7'd76: v = 15'd10442; 7'd77: v = 15'd11487;
			7'd78: v = 15'd12635; 7'd79: v = 15'd13899; 7'd80: v = 15'd15289;
			7'd81: v = 15'd16818; 7'd82: v = 15'd18500; 7'd83: v = 15'd20350;
			7'd84: v = 15'd22385; 7'd85: v = 15'd24623; 7'd86: v = 15'd27086;
			7'd87: v = 15'd29794;
			default: v = 15'd32767;
		endcase
		return v;
	endfunction

	function automatic logic signed [4:0] idx_adj(input logic [2:0] mag_code);
		logic signed [4:0] a;
		unique case (mag_code)
			3'd4:    a = 5'sd2;
			3'd5:    a = 5'sd4;
			3'd6:    a = 5'sd6;
			3'd7:    a = 5'sd8;
			default: a = -5'sd1;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/ima_adpcm_frame_encoder.sv
// top level: framed 4-bit ima adpcm encoder with a four-entry output buffer
// an accepted sample is registered in the input stage, then its bytes are loaded into the output buffer
// throughput: one sample per cycle while m_tready stays high; the frame-start sample holds the encoder
// while its header drains; the rate is set by the four-entry output shift buffer, which reloads
// only once it is empty or as its last byte leaves
// reset: arst_n clears predictor, step index, frame position, pending nibble, input valid, count
`timescale 1ns / 1ps

module ima_adpcm_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] data_byte
	output logic        m_tuser,  // [0] is_header
	output logic        m_tlast   // frame_last
);
	import imaenc_pkg::*;

	// input stage
	logic               vld_s1;
	logic signed [15:0] sample_s1;

	// encoder state
	enc_state_t         st_q;
	enc_state_t         st_nxt;
	logic [POS_W-1:0]   pos_q;
	logic [3:0]         pend_q;
	logic [3:0]         code;

	// output shift buffer, entry 0 faces the port
	out_entry_t         obuf_q [OUT_DEPTH];
	out_entry_t         load   [OUT_DEPTH];
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   load_cnt;

	logic               pop;
	logic               fire;
	logic               frame_start;
	logic               is_last;

	imaenc_core u_core (
		.sample (sample_s1),
		.cur    (st_q),
		.code   (code),
		.nxt    (st_nxt)
	);

	assign pop  = m_tvalid && m_tready;
	// the staged sample may move on once the buffer is empty or its last byte is leaving
	assign fire = vld_s1 && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_tready));
	assign s_tready = !vld_s1 || fire;

	assign frame_start = (pos_q == '0);
	assign is_last     = (pos_q == POS_W'(FRAME_SAMPLES - 1));

	// results of the staged sample
	always_comb begin
		for (int i = 0; i < OUT_DEPTH; i++) begin
			load[i] = '0;
		end
		load_cnt = '0;
		if (frame_start) begin
			// header carries the state from before this sample
			load[0]  = '{data_byte: st_q.predictor[7:0], is_header: 1'b1, frame_last: 1'b0};
			load[1]  = '{data_byte: st_q.predictor[15:8], is_header: 1'b1, frame_last: 1'b0};
			load[2]  = '{data_byte: {1'b0, st_q.step_index}, is_header: 1'b1, frame_last: 1'b0};
			load[3]  = '{data_byte: 8'd0, is_header: 1'b1, frame_last: 1'b0};
			load_cnt = CNT_W'(OUT_DEPTH);
		end else if (pos_q[0]) begin
			// odd position: pair with the waiting nibble
			load[0]  = '{data_byte: {code, pend_q}, is_header: 1'b0, frame_last: is_last};
			load_cnt = CNT_W'(1);
		end else if (is_last) begin
			// odd frame length: last code stands alone in the low nibble
			load[0]  = '{data_byte: {4'd0, code}, is_header: 1'b0, frame_last: 1'b1};
			load_cnt = CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			pos_q  <= '0;
			pend_q <= '0;
		end else if (fire) begin
			st_q   <= st_nxt;
			pos_q  <= is_last ? '0 : pos_q + POS_W'(1);
			pend_q <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= load_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < OUT_DEPTH; i++) begin
				obuf_q[i] <= load[i];
			end
		end else if (pop) begin
			for (int i = 0; i < OUT_DEPTH - 1; i++) begin
				obuf_q[i] <= obuf_q[i+1];
			end
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = obuf_q[0].data_byte;
	assign m_tuser  = obuf_q[0].is_header;
	assign m_tlast  = obuf_q[0].frame_last;

endmodule

// File: rtl/imaenc_core.sv
// one ima adpcm encode step: code and next predictor / step index
`timescale 1ns / 1ps

module imaenc_core (
	input  logic signed [15:0]     sample,
	input  imaenc_pkg::enc_state_t cur,
	output logic [3:0]             code,
	output imaenc_pkg::enc_state_t nxt
);
	import imaenc_pkg::*;

	logic [14:0]        step;
	logic [14:0]        half;
	logic [14:0]        quarter;
	logic signed [16:0] diff;
	logic               neg;
	logic [16:0]        mag0;
	logic [16:0]        mag1;
	logic [16:0]        mag2;
	logic               b2;
	logic               b1;
	logic               b0;
	logic [16:0]        delta;
	logic signed [17:0] pred_sum;
	logic signed [7:0]  idx_sum;

	always_comb begin
		step    = step_val(cur.step_index);
		half    = step >> 1;
		quarter = step >> 2;
		diff    = 17'(sample) - 17'(cur.predictor);
		neg     = diff[16];
		mag0    = neg ? 17'(-diff) : 17'(diff);

		// successive approximation over three magnitude bits
		b2   = mag0 >= {2'b00, step};
		mag1 = b2 ? mag0 - {2'b00, step} : mag0;
		b1   = mag1 >= {2'b00, half};
		mag2 = b1 ? mag1 - {2'b00, half} : mag1;
		b0   = mag2 >= {2'b00, quarter};

		delta = {2'b00, step >> 3}
			+ (b2 ? {2'b00, step} : 17'd0)
			+ (b1 ? {2'b00, half} : 17'd0)
			+ (b0 ? {2'b00, quarter} : 17'd0);

		code = {neg, b2, b1, b0};

		pred_sum = neg ? 18'(cur.predictor) - $signed({1'b0, delta})
			: 18'(cur.predictor) + $signed({1'b0, delta});
		if (pred_sum > PRED_MAX) begin
			nxt.predictor = 16'sd32767;
		end else if (pred_sum < PRED_MIN) begin
			nxt.predictor = -16'sd32768;
		end else begin
			nxt.predictor = pred_sum[15:0];
		end

		idx_sum = $signed({1'b0, cur.step_index}) + 8'(idx_adj({b2, b1, b0}));
		if (idx_sum < 8'sd0) begin
			nxt.step_index = 7'd0;
		end else if (idx_sum > $signed(8'(IDX_MAX))) begin
			nxt.step_index = 7'(IDX_MAX);
		end else begin
			nxt.step_index = idx_sum[6:0];
		end
	end

endmodule
